@@ design/soft_pwm_slot_table_unit_macros.svh @@
// Assertion macros shared by the soft PWM slot table unit.
`ifndef SOFT_PWM_SLOT_TABLE_UNIT_MACROS_SVH
`define SOFT_PWM_SLOT_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cond_a implies cond_c in the same cycle.
`define SPST_ASSERT_SAME(label, clk, rstn, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond_a) |-> (cond_c)) \
        else $error("same-cycle check failed");

// Check that cond_a implies cond_c in the next cycle.
`define SPST_ASSERT_NEXT(label, clk, rstn, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond_a) |=> (cond_c)) \
        else $error("next-cycle check failed");

`else

`define SPST_ASSERT_SAME(label, clk, rstn, cond_a, cond_c)
`define SPST_ASSERT_NEXT(label, clk, rstn, cond_a, cond_c)

`endif

`endif

@@ design/spst_pkg.sv @@
// Shared types, widths and codes of the soft PWM slot table unit.
package spst_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int PIN_W         = 8;
    localparam int DUTY_W        = 8;
    localparam int PHASE_W       = 7;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 4;
    localparam int MASK_W        = 16;

    localparam logic [PHASE_W-1:0] PHASE_MASK = 7'h7F;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TICK    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

@@ design/spst_ctrl.sv @@
// Controller of the soft PWM slot table unit: handshakes and sequencing.
module spst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output spst_pkg::cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = s_valid && (state_reg == S_IDLE);
    assign cmd.commit  = (state_reg == S_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // Hold until the result register can take the new beat.
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/spst_datapath.sv @@
// Datapath of the soft PWM slot table unit: slot lanes, phase and result registers.
module spst_datapath #(
    parameter int SLOTS = spst_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spst_pkg::cmd_t                 cmd,
    input  logic                           s_op,
    input  logic [spst_pkg::PIN_W-1:0]     s_pin,
    input  logic [spst_pkg::DUTY_W-1:0]    s_duty_value,
    output logic [spst_pkg::STATUS_W-1:0]  m_status,
    output logic [spst_pkg::SLOT_W-1:0]    m_slot,
    output logic [spst_pkg::MASK_W-1:0]    m_level_mask,
    output logic [spst_pkg::PHASE_W-1:0]   m_phase
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WIDE_W = (IDX_W > spst_pkg::SLOT_W) ? IDX_W : spst_pkg::SLOT_W;

    // Slot lanes.
    logic [spst_pkg::PIN_W-1:0]   pin_reg  [SLOTS];
    logic [spst_pkg::DUTY_W-1:0]  duty_reg [SLOTS];
    logic [SLOTS-1:0]             level_reg;
    logic [SLOTS-1:0]             level_next;
    logic [CNT_W-1:0]             used_reg;
    logic [CNT_W-1:0]             used_next;
    logic [spst_pkg::PHASE_W-1:0] phase_reg;
    logic [spst_pkg::PHASE_W-1:0] phase_next;

    // Captured item and lookup result.
    logic                         op_reg;
    logic [spst_pkg::PIN_W-1:0]   pin_in_reg;
    logic [spst_pkg::DUTY_W-1:0]  duty_in_reg;
    logic [SLOTS-1:0]             match_reg;
    logic [SLOTS-1:0]             match_next;

    // Result payload.
    logic [spst_pkg::STATUS_W-1:0] status_reg;
    logic [spst_pkg::STATUS_W-1:0] status_next;
    logic [spst_pkg::SLOT_W-1:0]   slot_reg;
    logic [spst_pkg::SLOT_W-1:0]   slot_next;

    logic                         found;
    logic                         full;
    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             sel_idx;
    logic [WIDE_W-1:0]            sel_wide;
    logic [spst_pkg::DUTY_W:0]    duty_sum;
    logic [spst_pkg::DUTY_W-1:0]  duty_half;
    logic [SLOTS-1:0]             pin_we;
    logic [SLOTS-1:0]             duty_we;

    // Compare the incoming pin against every used lane.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_next[i] = (pin_reg[i] == s_pin) && (CNT_W'(i) < used_reg);
        end
    end

    // Pins in the table are unique, so OR the indexes of the hit lanes.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (match_reg[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign found     = |match_reg;
    assign full      = (used_reg == CNT_W'(SLOTS));
    assign duty_sum  = {1'b0, duty_in_reg} + {{spst_pkg::DUTY_W{1'b0}}, 1'b1};
    assign duty_half = duty_sum[spst_pkg::DUTY_W:1];
    assign sel_idx   = found ? hit_idx : used_reg[IDX_W-1:0];
    assign sel_wide  = WIDE_W'(sel_idx);

    always_comb begin
        pin_we      = '0;
        duty_we     = '0;
        level_next  = level_reg;
        used_next   = used_reg;
        phase_next  = phase_reg;
        status_next = spst_pkg::STATUS_TICK;
        slot_next   = '0;
        if (op_reg == spst_pkg::OP_SET) begin
            if (found) begin
                status_next = spst_pkg::STATUS_UPDATED;
                slot_next   = sel_wide[spst_pkg::SLOT_W-1:0];
                duty_we     = match_reg;
            end else if (full) begin
                status_next = spst_pkg::STATUS_FULL;
            end else begin
                status_next = spst_pkg::STATUS_NEW;
                slot_next   = sel_wide[spst_pkg::SLOT_W-1:0];
                for (int i = 0; i < SLOTS; i++) begin
                    if (CNT_W'(i) == used_reg) begin
                        pin_we[i]     = 1'b1;
                        duty_we[i]    = 1'b1;
                        level_next[i] = 1'b0;
                    end
                end
                used_next = used_reg + CNT_W'(1);
            end
        end else if (used_reg != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (CNT_W'(i) < used_reg) begin
                    if (phase_reg == '0) begin
                        level_next[i] = (duty_reg[i] != '0);
                    end else if (duty_reg[i] == {1'b0, phase_reg}) begin
                        level_next[i] = 1'b0;
                    end
                end
            end
            phase_next = (phase_reg + spst_pkg::PHASE_W'(1)) & spst_pkg::PHASE_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            used_reg  <= '0;
            phase_reg <= '0;
        end else if (cmd.commit) begin
            level_reg <= level_next;
            used_reg  <= used_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (cmd.commit && pin_we[i]) begin
                pin_reg[i] <= pin_in_reg;
            end
            if (cmd.commit && duty_we[i]) begin
                duty_reg[i] <= duty_half;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_op;
            pin_in_reg  <= s_pin;
            duty_in_reg <= s_duty_value;
            match_reg   <= match_next;
        end
        if (cmd.commit) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    // Slots past the table's end read as low.
    always_comb begin
        m_level_mask = '0;
        for (int i = 0; i < spst_pkg::MASK_W; i++) begin
            if (i < SLOTS) begin
                m_level_mask[i] = level_reg[i];
            end
        end
    end

    assign m_status = status_reg;
    assign m_slot   = slot_reg;
    assign m_phase  = phase_reg;

endmodule

@@ design/soft_pwm_slot_table_unit.sv @@
// Top level of the soft PWM slot table unit.
`include "soft_pwm_slot_table_unit_macros.svh"

// Multi-channel 7-bit soft PWM with a pin-to-slot table of SLOTS entries. A set
// beat (op 0) looks its pin up among the slots in use; a hit rewrites that slot's
// duty, a miss takes the next free slot (its level starts low), and a miss on a
// full table changes nothing and reports status 2. The stored duty is
// (duty_value + 1) / 2, so 255 keeps a slot high for the whole period. A tick beat
// (op 1) does nothing until a slot exists; after that, at phase 0 every used slot
// goes high if its duty is nonzero, at other phases a slot goes low when its duty
// equals the phase, and the 7-bit phase then advances and wraps. Every beat gives
// exactly one result beat with status, slot, the levels of slots 0 to 15 and the
// phase after the beat. On capture the unit compares the pin against all lanes
// in parallel and registers the hit vector; on commit it encodes the hit and
// updates the lanes, the phase and the result register. The unit holds one item
// at a time, so it takes no new beat until the last one is committed; it takes
// the next input beat while a finished result still waits on m_ready, and holds
// that item's update until the result register is free.
module soft_pwm_slot_table_unit #(
    parameter int SLOTS = spst_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [spst_pkg::PIN_W-1:0]     s_pin,
    input  logic [spst_pkg::DUTY_W-1:0]    s_duty_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [spst_pkg::STATUS_W-1:0]  m_status,
    output logic [spst_pkg::SLOT_W-1:0]    m_slot,
    output logic [spst_pkg::MASK_W-1:0]    m_level_mask,
    output logic [spst_pkg::PHASE_W-1:0]   m_phase
);

    spst_pkg::cmd_t cmd;

    // Sequence beats: capture, then commit once the result register is free.
    spst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold the slot lanes, the phase counter and the result payload.
    spst_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_op),
        .s_pin        (s_pin),
        .s_duty_value (s_duty_value),
        .m_status     (m_status),
        .m_slot       (m_slot),
        .m_level_mask (m_level_mask),
        .m_phase      (m_phase)
    );

    // One item in flight: an accepted beat drops ready for the next cycle.
    `SPST_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A commit always presents a result beat.
    `SPST_ASSERT_NEXT(a_commit_shows_result, aclk, aresetn, cmd.commit, m_valid)
    // Never overwrite a result that is still stalled.
    `SPST_ASSERT_SAME(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !cmd.commit)
    // Capture and commit never coincide.
    `SPST_ASSERT_SAME(a_capture_commit_apart, aclk, aresetn, cmd.capture, !cmd.commit)

endmodule
